// ===== src/mtpc_pkg.sv =====
`default_nettype none

package mtpc_pkg;

	// Operation codes carried in s_axis_tuser
	localparam logic [2:0] OP_RESTART  = 3'd0;
	localparam logic [2:0] OP_WRITE    = 3'd1;
	localparam logic [2:0] OP_VERIFY   = 3'd2;
	localparam logic [2:0] OP_CLEAR    = 3'd3;
	localparam logic [2:0] OP_READ_LOG = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] REG_TEST_MODE    = 3'd0;
	localparam logic [2:0] REG_FILL_PATTERN = 3'd1;
	localparam logic [2:0] REG_SEED_VALUE   = 3'd2;
	localparam logic [2:0] REG_BASE_ADDRESS = 3'd3;
	localparam logic [2:0] REG_WORD_COUNT   = 3'd4;

	// Test modes
	localparam logic MODE_FIXED  = 1'b0;
	localparam logic MODE_RANDOM = 1'b1;

	localparam int MAX_LOGGED_FAILS_DEFAULT = 16;
	localparam int INDEX_W = 22;

	// Front to back queue
	localparam int Q_DEPTH = 2;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [2:0]  op;
		logic        step;       // write or verify step inside the region
		logic        last;       // step handled the final word
		logic [31:0] addr;
		logic [31:0] value;      // zero unless step
		logic [31:0] read_word;
		logic [3:0]  log_index;
	} q_item_t;

	// xorshift32, shifts 13, 17, 5
	function automatic logic [31:0] next_random(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		a = v ^ (v << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

`default_nettype wire

// ===== src/memory_test_pattern_checker.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser operation, tdata read_word, log_index
// m_axis    out  m_axis_tvalid/m_axis_tready    tuser mismatch, tlast last_word, tdata results
// cfg       in   cfg_valid/cfg_ready            cfg_index register, cfg_data value
//
// One transaction per clock while m_axis_tready stays high; a result passes through the
// queue entry, the record update with log RAM read and the output register before it is offered.
// The front keeps the generator and word index and updates them in the accept cycle;
// the back keeps counters, masks and the failure log RAM (one read port, registered).
// A two-entry queue parts them, so s_axis_tready drops only when the queue is full.
// arst_n clears all control and record state at once; the log RAM needs no clearing.
`default_nettype none

module memory_test_pattern_checker #(
	parameter int MAX_LOGGED_FAILS = mtpc_pkg::MAX_LOGGED_FAILS_DEFAULT,
	parameter int CNT_W = $clog2(MAX_LOGGED_FAILS + 1),
	parameter int OUT_W = ((288 + CNT_W + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [31:0]      cfg_data,
	// input stream
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [39:0]      s_axis_tdata,  // read_word[31:0], log_index[35:32]
	input  wire logic [2:0]       s_axis_tuser,  // operation
	// result stream
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// word_address, word_value, error_total, bad_bits_all, bad_bits_odd,
	// bad_bits_even, logged_count, log_address, log_expected, log_actual
	output logic [OUT_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tlast,  // last_word
	output logic                  m_axis_tuser   // mismatch
);

	logic              push;
	logic              q_full;
	logic              pop;
	logic              head_valid;
	mtpc_pkg::q_item_t push_item;
	mtpc_pkg::q_item_t head_item;

	mtpc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	mtpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	mtpc_back #(
		.MAX_LOGGED_FAILS(MAX_LOGGED_FAILS),
		.CNT_W           (CNT_W),
		.OUT_W           (OUT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ===== src/mtpc_ram.sv =====
`default_nettype none

module mtpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/mtpc_front.sv =====
`default_nettype none

module mtpc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration writes
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	// input stream
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [39:0]        s_axis_tdata,
	input  wire logic [2:0]         s_axis_tuser,
	// queue push side
	output logic                    push,
	output mtpc_pkg::q_item_t       push_item,
	input  wire logic               q_full
);

	logic        test_mode_q;
	logic [31:0] fill_pattern_q;
	logic [31:0] seed_value_q;
	logic [31:0] base_address_q;
	logic [mtpc_pkg::INDEX_W-1:0] word_count_q;

	logic [31:0] gen_q;
	logic [mtpc_pkg::INDEX_W-1:0] index_q;

	logic [2:0]  op;
	logic        is_step;
	logic [mtpc_pkg::INDEX_W-1:0] index_eff;
	logic [mtpc_pkg::INDEX_W-1:0] index_inc;
	logic [31:0] gen_adv;
	logic [31:0] word_val;
	logic        cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign s_axis_tready = !q_full;
	assign push = s_axis_tvalid && s_axis_tready;
	assign op = s_axis_tuser;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_mode_q    <= mtpc_pkg::MODE_RANDOM;
			fill_pattern_q <= '0;
			seed_value_q   <= 32'd1;
			base_address_q <= '0;
			word_count_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				mtpc_pkg::REG_TEST_MODE:    test_mode_q    <= cfg_data[0];
				mtpc_pkg::REG_FILL_PATTERN: fill_pattern_q <= cfg_data;
				mtpc_pkg::REG_SEED_VALUE:   seed_value_q   <= cfg_data;
				mtpc_pkg::REG_BASE_ADDRESS: base_address_q <= cfg_data;
				mtpc_pkg::REG_WORD_COUNT:   word_count_q   <= cfg_data[mtpc_pkg::INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	// Classify the transaction and build the word for this step
	always_comb begin
		index_eff = (op == mtpc_pkg::OP_RESTART) ? '0 : index_q;
		is_step = ((op == mtpc_pkg::OP_WRITE) || (op == mtpc_pkg::OP_VERIFY))
			&& (index_q < word_count_q);
		index_inc = index_q + 1'b1;
		gen_adv = mtpc_pkg::next_random(gen_q);
		word_val = (test_mode_q == mtpc_pkg::MODE_RANDOM) ? gen_adv : fill_pattern_q;

		push_item.op        = op;
		push_item.step      = is_step;
		push_item.last      = is_step && (index_inc == word_count_q);
		push_item.addr      = base_address_q + 32'({index_eff, 2'b00});
		push_item.value     = is_step ? word_val : '0;
		push_item.read_word = s_axis_tdata[31:0];
		push_item.log_index = s_axis_tdata[35:32];
	end

	// Generator and word index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q   <= 32'd1;
			index_q <= '0;
		end else if (push) begin
			if (op == mtpc_pkg::OP_RESTART) begin
				gen_q   <= (seed_value_q == '0) ? 32'd1 : seed_value_q;
				index_q <= '0;
			end else if (is_step) begin
				index_q <= index_inc;
				if (test_mode_q == mtpc_pkg::MODE_RANDOM) begin
					gen_q <= gen_adv;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/mtpc_queue.sv =====
`default_nettype none

module mtpc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mtpc_pkg::q_item_t  push_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    head_valid,
	output mtpc_pkg::q_item_t       head_item
);

	mtpc_pkg::q_item_t             slot_q [mtpc_pkg::Q_DEPTH];
	logic [mtpc_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [mtpc_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [mtpc_pkg::Q_CW-1:0]     count_q;

	assign full = (count_q == mtpc_pkg::Q_CW'(mtpc_pkg::Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == mtpc_pkg::Q_AW'(mtpc_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == mtpc_pkg::Q_AW'(mtpc_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/mtpc_back.sv =====
`default_nettype none

module mtpc_back #(
	parameter int MAX_LOGGED_FAILS = mtpc_pkg::MAX_LOGGED_FAILS_DEFAULT,
	parameter int CNT_W = $clog2(MAX_LOGGED_FAILS + 1),
	parameter int OUT_W = ((288 + CNT_W + 7) / 8) * 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// queue pop side
	input  wire logic               head_valid,
	input  wire mtpc_pkg::q_item_t  head_item,
	output logic                    pop,
	// result stream
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [OUT_W-1:0]        m_axis_tdata,
	output logic                    m_axis_tlast,
	output logic                    m_axis_tuser
);

	localparam int LOG_AW = (MAX_LOGGED_FAILS > 1) ? $clog2(MAX_LOGGED_FAILS) : 1;
	localparam int CMP_W = CNT_W + 4;

	// record state
	logic [31:0]      err_q;
	logic [31:0]      all_q;
	logic [31:0]      odd_q;
	logic [31:0]      even_q;
	logic [CNT_W-1:0] cnt_q;

	// next record state
	logic [31:0]      err_n;
	logic [31:0]      all_n;
	logic [31:0]      odd_n;
	logic [31:0]      even_n;
	logic [CNT_W-1:0] cnt_n;

	logic [31:0]      diff;
	logic             miss;
	logic             is_clear;
	logic             is_read;
	logic             log_we;
	logic             log_ok;
	logic [CMP_W-1:0] sel_w;
	logic [95:0]      log_rdata;

	// stage 1: record updated, log read issued
	logic             valid_s1;
	logic [31:0]      addr_s1;
	logic [31:0]      value_s1;
	logic             miss_s1;
	logic             last_s1;
	logic [31:0]      err_s1;
	logic [31:0]      all_s1;
	logic [31:0]      odd_s1;
	logic [31:0]      even_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             log_ok_s1;

	// stage 2: output register
	logic             valid_s2;
	logic [31:0]      addr_s2;
	logic [31:0]      value_s2;
	logic             miss_s2;
	logic             last_s2;
	logic [31:0]      err_s2;
	logic [31:0]      all_s2;
	logic [31:0]      odd_s2;
	logic [31:0]      even_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic [95:0]      log_s2;

	logic             load_s1;
	logic             load_s2;

	// Pipeline advance
	assign load_s2 = valid_s1 && (!valid_s2 || m_axis_tready);
	assign load_s1 = head_valid && (!valid_s1 || load_s2);
	assign pop = load_s1;

	// Verify, record update and log write for the queue head
	always_comb begin
		is_clear = (head_item.op == mtpc_pkg::OP_CLEAR);
		is_read  = (head_item.op == mtpc_pkg::OP_READ_LOG);
		diff = head_item.value ^ head_item.read_word;
		miss = head_item.step && (head_item.op == mtpc_pkg::OP_VERIFY) && (diff != '0);
		log_we = load_s1 && miss && (cnt_q < CNT_W'(MAX_LOGGED_FAILS));

		if (is_clear) begin
			err_n  = '0;
			all_n  = '0;
			odd_n  = '0;
			even_n = '0;
			cnt_n  = '0;
		end else begin
			err_n  = (miss && (err_q != '1)) ? err_q + 1'b1 : err_q;
			all_n  = miss ? (all_q | diff) : all_q;
			odd_n  = (miss && head_item.addr[2]) ? (odd_q | diff) : odd_q;
			even_n = (miss && !head_item.addr[2]) ? (even_q | diff) : even_q;
			cnt_n  = log_we ? cnt_q + 1'b1 : cnt_q;
		end

		sel_w = CMP_W'(head_item.log_index);
		log_ok = is_read && (sel_w < CMP_W'(cnt_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= '0;
			all_q  <= '0;
			odd_q  <= '0;
			even_q <= '0;
			cnt_q  <= '0;
		end else if (load_s1) begin
			err_q  <= err_n;
			all_q  <= all_n;
			odd_q  <= odd_n;
			even_q <= even_n;
			cnt_q  <= cnt_n;
		end
	end

	// Failure log: address, expected, actual
	mtpc_ram #(
		.WIDTH (96),
		.DEPTH (MAX_LOGGED_FAILS),
		.ADDR_W(LOG_AW)
	) u_log_ram (
		.clk  (clk),
		.we   (log_we),
		.waddr(cnt_q[LOG_AW-1:0]),
		.wdata({head_item.addr, head_item.value, head_item.read_word}),
		.re   (load_s1 && is_read),
		.raddr(sel_w[LOG_AW-1:0]),
		.rdata(log_rdata)
	);

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			addr_s1   <= head_item.addr;
			value_s1  <= head_item.value;
			miss_s1   <= miss;
			last_s1   <= head_item.last;
			err_s1    <= err_n;
			all_s1    <= all_n;
			odd_s1    <= odd_n;
			even_s1   <= even_n;
			cnt_s1    <= cnt_n;
			log_ok_s1 <= log_ok;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			addr_s2  <= addr_s1;
			value_s2 <= value_s1;
			miss_s2  <= miss_s1;
			last_s2  <= last_s1;
			err_s2   <= err_s1;
			all_s2   <= all_s1;
			odd_s2   <= odd_s1;
			even_s2  <= even_s1;
			cnt_s2   <= cnt_s1;
			log_s2   <= log_ok_s1 ? log_rdata : '0;
		end
	end

	// Result packing, lowest field first
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[287+CNT_W:0] = {log_s2[31:0], log_s2[63:32], log_s2[95:64], cnt_s2,
			even_s2, odd_s2, all_s2, err_s2, value_s2, addr_s2};
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = last_s2;
	assign m_axis_tuser  = miss_s2;

endmodule

`default_nettype wire

// ===== src/mtpc_checker.sv =====
`default_nettype none

module mtpc_checker #(
	parameter int MAX_LOGGED_FAILS = mtpc_pkg::MAX_LOGGED_FAILS_DEFAULT,
	parameter int CNT_W = $clog2(MAX_LOGGED_FAILS + 1),
	parameter int OUT_W = ((288 + CNT_W + 7) / 8) * 8
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata,
	input wire logic             m_axis_tlast,
	input wire logic             m_axis_tuser
);

	logic [31:0]      err_total;
	logic [31:0]      bad_all;
	logic [31:0]      bad_odd;
	logic [31:0]      bad_even;
	logic [CNT_W-1:0] logged;

	assign err_total = m_axis_tdata[95:64];
	assign bad_all   = m_axis_tdata[127:96];
	assign bad_odd   = m_axis_tdata[159:128];
	assign bad_even  = m_axis_tdata[191:160];
	assign logged    = m_axis_tdata[191+CNT_W:192];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
			&& $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// a mismatch shows up in the count and the total mask
	a_miss_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (err_total != '0) && (bad_all != '0)
			&& (logged != '0))
		else $error("mismatch not recorded");

	// bank masks together make up the total mask
	a_banks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((bad_odd | bad_even) == bad_all))
		else $error("bank masks disagree with total mask");

	// log fill bounded
	a_log_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (logged <= CNT_W'(MAX_LOGGED_FAILS)))
		else $error("log count beyond capacity");

endmodule

bind memory_test_pattern_checker mtpc_checker #(
	.MAX_LOGGED_FAILS(MAX_LOGGED_FAILS),
	.CNT_W           (CNT_W),
	.OUT_W           (OUT_W)
) u_mtpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// ===== dv/tb_memory_test_pattern_checker.sv =====
`default_nettype none

module tb_memory_test_pattern_checker;
	import mtpc_pkg::*;

	localparam int REPORT_W   = ((288 + 5 + 7) / 8) * 8;
	localparam int LOG_DEPTH  = MAX_LOGGED_FAILS_DEFAULT;
	localparam int LONG_HOLD  = 150;
	localparam int ITEM_GOAL  = 1950;

	// Operation codes the block does not use
	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;

	// One report of the block, unpacked
	typedef struct {
		logic [31:0] addr, value;
		logic        miss, last;
		logic [31:0] errors, bits_all, bits_odd, bits_even;
		logic [4:0]  logged;
		logic [31:0] log_addr, log_exp, log_act;
	} step_report_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		logic [2:0]   op;
		logic [31:0]  rd;
		logic [3:0]   li;
		logic [2:0]   reg_idx;
		logic [31:0]  reg_val;
		bit           typed;
		step_report_t report;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [2:0]          cfg_index;
	logic [31:0]         cfg_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [39:0]         s_axis_tdata;
	logic [2:0]          s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [REPORT_W-1:0] m_axis_tdata;
	logic                m_axis_tlast;
	logic                m_axis_tuser;

	memory_test_pattern_checker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the registers and the test engine state
	logic        cfg_mode;
	logic [31:0] cfg_fill, cfg_seed, cfg_base;
	logic [21:0] cfg_count;
	logic [31:0] gen_word;
	logic [21:0] word_idx;
	logic [31:0] err_cnt, mask_all, mask_odd, mask_even;
	logic [4:0]  log_cnt;
	logic [31:0] log_addr_mem [LOG_DEPTH];
	logic [31:0] log_exp_mem  [LOG_DEPTH];
	logic [31:0] log_act_mem  [LOG_DEPTH];

	step_report_t expected_reports[$];
	stim_row_t    stim_table[$];
	step_report_t no_report;
	int           mismatches = 0;
	int           burst_left = 0;
	int           counted_items = 0;
	int           hold_requested = 0;
	int           hold_served = 0;

	function automatic logic [31:0] xorshift_next(input logic [31:0] w);
		logic [31:0] x;
		x = w;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	function automatic step_report_t blank_report(input logic [31:0] addr);
		step_report_t r;
		r.addr = addr;
		r.value = '0;
		r.miss = 1'b0;
		r.last = 1'b0;
		r.errors = '0;
		r.bits_all = '0;
		r.bits_odd = '0;
		r.bits_even = '0;
		r.logged = '0;
		r.log_addr = '0;
		r.log_exp = '0;
		r.log_act = '0;
		return r;
	endfunction

	function automatic void engine_reset();
		cfg_mode = MODE_RANDOM;
		cfg_fill = '0;
		cfg_seed = 32'd1;
		cfg_base = '0;
		cfg_count = '0;
		gen_word = 32'd1;
		word_idx = '0;
		err_cnt = '0;
		mask_all = '0;
		mask_odd = '0;
		mask_even = '0;
		log_cnt = '0;
	endfunction

	function automatic logic [31:0] next_expected_word();
		return (cfg_mode == MODE_RANDOM) ? xorshift_next(gen_word) : cfg_fill;
	endfunction

	function automatic bit step_in_region(input logic [2:0] op);
		return (op == OP_WRITE || op == OP_VERIFY) && (word_idx < cfg_count);
	endfunction

	// Advance the engine by one transaction and return the report it gives
	function automatic step_report_t predict_step(input logic [2:0] op,
			input logic [31:0] rd, input logic [3:0] li);
		step_report_t r;
		logic [31:0]  addr;
		logic [31:0]  word;
		logic [31:0]  diff;
		r = blank_report('0);
		case (op)
			OP_RESTART: begin
				gen_word = (cfg_seed == '0) ? 32'd1 : cfg_seed;
				word_idx = '0;
			end
			OP_CLEAR: begin
				err_cnt = '0;
				mask_all = '0;
				mask_odd = '0;
				mask_even = '0;
				log_cnt = '0;
			end
			OP_READ_LOG: begin
				if (5'(li) < log_cnt) begin
					r.log_addr = log_addr_mem[li];
					r.log_exp = log_exp_mem[li];
					r.log_act = log_act_mem[li];
				end
			end
			default: ;
		endcase
		addr = cfg_base + {8'd0, word_idx, 2'b00};
		r.addr = addr;
		if (step_in_region(op)) begin
			if (cfg_mode == MODE_RANDOM) begin
				gen_word = xorshift_next(gen_word);
				word = gen_word;
			end else begin
				word = cfg_fill;
			end
			r.value = word;
			r.last = (int'(word_idx) + 1 == int'(cfg_count));
			if (op == OP_VERIFY && rd != word) begin
				r.miss = 1'b1;
				diff = rd ^ word;
				if (err_cnt != 32'hFFFF_FFFF)
					err_cnt = err_cnt + 1;
				mask_all = mask_all | diff;
				if (addr[2])
					mask_odd = mask_odd | diff;
				else
					mask_even = mask_even | diff;
				if (log_cnt < LOG_DEPTH) begin
					log_addr_mem[log_cnt] = addr;
					log_exp_mem[log_cnt] = word;
					log_act_mem[log_cnt] = rd;
					log_cnt = log_cnt + 1;
				end
			end
			word_idx = word_idx + 1;
		end
		r.errors = err_cnt;
		r.bits_all = mask_all;
		r.bits_odd = mask_odd;
		r.bits_even = mask_even;
		r.logged = log_cnt;
		return r;
	endfunction

	// Stop offering and wait until every outstanding report came back
	task automatic wait_results_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_TEST_MODE:    cfg_mode = val[0];
			REG_FILL_PATTERN: cfg_fill = val;
			REG_SEED_VALUE:   cfg_seed = val;
			REG_BASE_ADDRESS: cfg_base = val;
			REG_WORD_COUNT:   cfg_count = val[21:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offer one transaction in bursts with random gaps; predict on acceptance
	task automatic issue(input logic [2:0] op, input logic [31:0] rd, input logic [3:0] li,
			input bit typed, input step_report_t typed_report);
		int           gap;
		step_report_t r;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {4'h0, 4'($urandom), 32'($urandom)};
			s_axis_tuser <= 3'($urandom);
			repeat (gap - 1)
				@(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'h0, li, rd};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (op <= OP_READ_LOG && (op == OP_RESTART || op >= OP_CLEAR || step_in_region(op)))
			counted_items++;
		r = predict_step(op, rd, li);
		expected_reports.push_back(typed ? typed_report : r);
		burst_left--;
	endtask

	task automatic random_item(input logic [2:0] op, input logic [31:0] rd);
		issue(op, rd, 4'($urandom), 1'b0, no_report);
	endtask

	task automatic add_item(input logic [2:0] op, input logic [31:0] rd, input logic [3:0] li);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.op = op;
		row.rd = rd;
		row.li = li;
		row.typed = 1'b0;
		stim_table.push_back(row);
	endtask

	task automatic add_typed(input logic [2:0] op, input logic [31:0] rd, input logic [3:0] li,
			input step_report_t rep);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.op = op;
		row.rd = rd;
		row.li = li;
		row.typed = 1'b1;
		row.report = rep;
		stim_table.push_back(row);
	endtask

	task automatic add_reg(input logic [2:0] idx, input logic [31:0] val);
		stim_row_t row;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		stim_table.push_back(row);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Random write pass then verify pass over a small region, then log reads
	task automatic random_pass(input bit squeeze);
		int          n;
		int          err_pct;
		logic [31:0] rd;
		logic [31:0] flip;
		wait_results_idle();
		if ($urandom_range(0, 9) < 7)
			write_reg(REG_TEST_MODE, 32'($urandom_range(0, 1)));
		if ($urandom_range(0, 9) < 7)
			write_reg(REG_FILL_PATTERN, pick_word());
		if ($urandom_range(0, 9) < 7)
			write_reg(REG_SEED_VALUE, pick_word());
		if ($urandom_range(0, 9) < 7)
			write_reg(REG_BASE_ADDRESS, pick_word());
		if (squeeze)
			write_reg(REG_WORD_COUNT, 32'($urandom_range(40, 60)));
		else if ($urandom_range(0, 9) < 8)
			case ($urandom_range(0, 15))
				0:       write_reg(REG_WORD_COUNT, 32'd0);
				1:       write_reg(REG_WORD_COUNT, 32'h0020_0000);
				default: write_reg(REG_WORD_COUNT, 32'($urandom_range(1, 24)));
			endcase
		case ($urandom_range(0, 3))
			0:       err_pct = 0;
			1:       err_pct = 10;
			2:       err_pct = 40;
			default: err_pct = 100;
		endcase
		n = (int'(cfg_count) > 60) ? $urandom_range(1, 24) : int'(cfg_count);
		n = n + $urandom_range(0, 1);
		if (squeeze) begin
			hold_requested++;
			burst_left = 1000;
		end
		if ($urandom_range(0, 4) != 0)
			random_item(OP_RESTART, $urandom);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 19) == 0)
				random_item(3'($urandom), $urandom);
			random_item(OP_WRITE, $urandom);
		end
		random_item(OP_RESTART, $urandom);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 19) == 0)
				random_item(3'($urandom), $urandom);
			rd = next_expected_word();
			if ($urandom_range(0, 99) < err_pct) begin
				flip = ($urandom_range(0, 2) == 0) ? (32'd1 << $urandom_range(0, 31)) : $urandom;
				rd = rd ^ ((flip == '0) ? 32'h8000_0000 : flip);
			end
			random_item(OP_VERIFY, rd);
		end
		repeat ($urandom_range(1, 4))
			random_item(OP_READ_LOG, $urandom);
		if ($urandom_range(0, 9) == 0)
			random_item(OP_CLEAR, $urandom);
	endtask

	// Receiver: ready pattern of its own plus a long hold when asked
	initial begin : result_sink
		int span;
		int style;
		m_axis_tready = 1'b0;
		forever begin
			if (hold_served != hold_requested) begin
				hold_served++;
				for (int c = 0; c < LONG_HOLD; c++) begin
					@(negedge clk);
					m_axis_tready <= 1'b0;
				end
			end else begin
				style = $urandom_range(0, 2);
				span = $urandom_range(8, 60);
				for (int c = 0; c < span; c++) begin
					if (hold_served != hold_requested)
						break;
					@(negedge clk);
					case (style)
						0:       m_axis_tready <= 1'b1;
						1:       m_axis_tready <= 1'($urandom);
						default: m_axis_tready <= (c % 5 < 2) ? 1'b0 : 1'b1;
					endcase
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare every accepted result transaction with the oldest prediction
	always @(posedge clk) begin
		step_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: result expected none, got address %h", $time,
					m_axis_tdata[31:0]);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				check_field("word_address", want.addr, m_axis_tdata[31:0]);
				check_field("word_value", want.value, m_axis_tdata[63:32]);
				check_field("mismatch", 32'(want.miss), 32'(m_axis_tuser));
				check_field("last_word", 32'(want.last), 32'(m_axis_tlast));
				check_field("error_total", want.errors, m_axis_tdata[95:64]);
				check_field("bad_bits_all", want.bits_all, m_axis_tdata[127:96]);
				check_field("bad_bits_odd", want.bits_odd, m_axis_tdata[159:128]);
				check_field("bad_bits_even", want.bits_even, m_axis_tdata[191:160]);
				check_field("logged_count", 32'(want.logged), 32'(m_axis_tdata[196:192]));
				check_field("log_address", want.log_addr, m_axis_tdata[228:197]);
				check_field("log_expected", want.log_exp, m_axis_tdata[260:229]);
				check_field("log_actual", want.log_act, m_axis_tdata[292:261]);
			end
		end
	end

	initial begin : run_limit
		#3_000_000;
		$display("tb_memory_test_pattern_checker: done, errors");
		$finish;
	end

	initial begin : stimulus
		step_report_t rep;
		int           phase;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_RESTART;
		no_report = blank_report('0);
		engine_reset();

		// Reset values: empty region, nothing logged, spare codes ignored
		add_typed(OP_READ_LOG, 32'h0, 4'd0, blank_report(32'h0));
		add_typed(OP_WRITE, 32'h0, 4'd0, blank_report(32'h0));
		add_typed(OP_VERIFY, 32'hFFFF_FFFF, 4'd15, blank_report(32'h0));
		add_typed(OP_SPARE_LO, 32'hFFFF_FFFF, 4'd15, blank_report(32'h0));
		add_typed(OP_SPARE_MID, 32'h0, 4'd0, blank_report(32'h0));
		add_typed(OP_SPARE_HI, 32'hA5A5_5A5A, 4'd7, blank_report(32'h0));

		// Fixed fill, region wrapping past the top of the address space
		add_reg(REG_TEST_MODE, 32'(MODE_FIXED));
		add_reg(REG_FILL_PATTERN, 32'hFFFF_FFFF);
		add_reg(REG_BASE_ADDRESS, 32'hFFFF_FFF8);
		add_reg(REG_WORD_COUNT, 32'd3);
		add_typed(OP_RESTART, 32'h0, 4'd0, blank_report(32'hFFFF_FFF8));
		rep = blank_report(32'hFFFF_FFF8);
		rep.value = 32'hFFFF_FFFF;
		add_typed(OP_WRITE, 32'h0, 4'd0, rep);
		add_item(OP_WRITE, 32'h0, 4'd0);
		add_item(OP_WRITE, 32'h0, 4'd0);
		add_typed(OP_WRITE, 32'h0, 4'd0, blank_report(32'h0000_0004));
		add_item(OP_RESTART, 32'h0, 4'd0);
		add_item(OP_VERIFY, 32'h0000_0000, 4'd0);
		add_item(OP_VERIFY, 32'h7FFF_FFFE, 4'd0);
		add_item(OP_VERIFY, 32'hFFFF_FFFF, 4'd0);
		add_item(OP_READ_LOG, 32'h0, 4'd0);
		add_item(OP_READ_LOG, 32'h0, 4'd1);
		add_item(OP_READ_LOG, 32'h0, 4'd15);
		add_item(OP_CLEAR, 32'h0, 4'd0);
		add_item(OP_READ_LOG, 32'h0, 4'd0);

		// Pseudo-random mode: zero seed with a region of 0x200000 words, then all-ones seed
		add_reg(REG_TEST_MODE, 32'(MODE_RANDOM));
		add_reg(REG_SEED_VALUE, 32'h0);
		add_reg(REG_BASE_ADDRESS, 32'h0);
		add_reg(REG_WORD_COUNT, 32'h0020_0000);
		add_item(OP_RESTART, 32'h0, 4'd0);
		add_item(OP_WRITE, 32'h0, 4'd0);
		add_reg(REG_SEED_VALUE, 32'hFFFF_FFFF);
		add_reg(REG_FILL_PATTERN, 32'h0);
		add_reg(REG_WORD_COUNT, 32'd1);
		add_item(OP_RESTART, 32'h0, 4'd0);
		add_item(OP_VERIFY, 32'h0, 4'd0);
		add_item(OP_WRITE, 32'h0, 4'd0);

		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_REG) begin
				wait_results_idle();
				write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
			end else begin
				issue(stim_table[i].op, stim_table[i].rd, stim_table[i].li,
					stim_table[i].typed, stim_table[i].report);
			end
		end

		counted_items = 0;
		phase = 0;
		while (counted_items < ITEM_GOAL) begin
			phase++;
			random_pass(phase % 25 == 2);
		end

		wait_results_idle();
		repeat (10)
			@(posedge clk);
		if (expected_reports.size() != 0) begin
			$display("%0t: %0d results expected, got none", $time, expected_reports.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("tb_memory_test_pattern_checker: done, clean");
		else
			$display("tb_memory_test_pattern_checker: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
